// ----- hdl/tpr_pkg.sv -----
// Package for the transport stream identifier remapper.
// Holds sizes, the clearing state type and the output queue records.
// No dependencies.
package tpr_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = 8;
    localparam int ID_W         = 13;
    localparam int ID_COUNT     = 8192;
    localparam int ID_AW        = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int ENTRY_W      = ID_W + 1;
    localparam int FLAG_W       = 16 - ID_W;

    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);
    localparam int Q_ROOM  = Q_DEPTH - 2;

    localparam logic [POS_W-1:0] POS_HDR1 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HDR2 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_q_entry;

    typedef struct packed {
        logic [1:0] num;
        t_q_entry   e0;
        t_q_entry   e1;
    } t_q_push;

endpackage

// ----- hdl/tpr_if.sv -----
// Handshake channel interfaces for the identifier remapper.
// Depends on tpr_pkg for field widths.
interface tpr_in_if
    import tpr_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            action;
    logic [7:0]      data_byte;
    logic [ID_W-1:0] map_source;
    logic [ID_W-1:0] map_target;
    logic            map_enable;

    modport source (output valid, action, data_byte, map_source, map_target, map_enable,
                    input ready);
    modport sink (input valid, action, data_byte, map_source, map_target, map_enable,
                  output ready);
endinterface

interface tpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

// ----- hdl/ts_packet_pid_remapper_core.sv -----
// Transport stream packet identifier remapper, top level.
// Depends on tpr_pkg, tpr_in_if, tpr_out_if, tpr_ram and tpr_out_queue.
//
// The input channel carries stream bytes (action 0) and remap table writes (action 1).
// The output channel carries result bytes with a last flag that closes the results of
// one input transaction. Header byte 1 of each packet gives no result; header byte 2
// gives two, the rewritten byte 1 and then byte 2; every other byte gives one.
// A table write gives no result and takes effect for every later header.
// The remap table lives in one 8192 x 14 RAM. A header byte 2 reads it in the cycle of
// its transaction and the rewrite happens on the registered read data in the next cycle.
// Results pass through the stage-1 registers and then the result queue to the output.
// Throughput: one input transaction per cycle while the receiver takes one result per
// cycle; an eight-entry result queue absorbs the extra byte of each header pair, and
// input ready drops when the queue could not take the worst case of two more bytes.
// After reset a clearing pass writes every table entry to unmapped, one entry a cycle;
// input ready stays low until it is done.
// When the receiver stalls the queue fills and input ready drops; nothing is lost.
module ts_packet_pid_remapper_core
    import tpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tpr_in_if.sink    i_in,
    tpr_out_if.source o_out
);
    t_state             r_state;
    t_state             n_state;
    logic [ID_AW-1:0]   r_clr_addr;
    logic [POS_W-1:0]   r_pos;
    logic [7:0]         r_held;
    logic               r_s1_valid;
    logic               r_s1_hdr;
    logic               r_s1_in_range;
    logic [7:0]         r_s1_byte;
    logic [7:0]         r_s1_held;

    logic               w_acc;
    logic               w_stream;
    logic               w_write;
    logic [1:0]         w_s1_num;
    logic [Q_CW:0]      w_fill;
    logic [Q_CW-1:0]    w_q_count;
    logic [ID_W-1:0]    w_id;
    logic               w_ram_we;
    logic [ID_AW-1:0]   w_ram_waddr;
    logic [ENTRY_W-1:0] w_ram_wdata;
    logic [ENTRY_W-1:0] w_ram_rdata;
    logic [15:0]        w_header;
    logic               w_mapped;
    t_q_push            w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ID_AW'(ID_COUNT - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == ST_CLEAR) begin
            r_clr_addr <= r_clr_addr + ID_AW'(1);
        end
    end

    assign w_s1_num = !r_s1_valid ? 2'd0 : (r_s1_hdr ? 2'd2 : 2'd1);
    assign w_fill   = (Q_CW + 1)'(w_q_count) + (Q_CW + 1)'(w_s1_num);

    assign i_in.ready = (r_state == ST_RUN) && (w_fill <= (Q_CW + 1)'(Q_ROOM));
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_stream   = w_acc && !i_in.action;
    assign w_write    = w_acc && i_in.action
                        && ({1'b0, i_in.map_source} < (ID_W + 1)'(ID_COUNT));

    assign w_id = ID_W'({r_held, i_in.data_byte});

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_addr;
            w_ram_wdata = '0;
        end else begin
            w_ram_we    = w_write;
            w_ram_waddr = i_in.map_source[ID_AW-1:0];
            w_ram_wdata = {i_in.map_enable, i_in.map_target};
        end
    end

    tpr_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ID_COUNT)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_raddr(w_id[ID_AW-1:0]),
        .o_rdata(w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_held     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_stream && (r_pos != POS_HDR1);
            if (w_stream) begin
                r_pos <= (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
                if (r_pos == POS_HDR1) begin
                    r_held <= i_in.data_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hdr      <= (r_pos == POS_HDR2);
        r_s1_in_range <= ({1'b0, w_id} < (ID_W + 1)'(ID_COUNT));
        r_s1_byte     <= i_in.data_byte;
        r_s1_held     <= r_held;
    end

    assign w_mapped = r_s1_in_range && w_ram_rdata[ENTRY_W-1];
    assign w_header = w_mapped ? {r_s1_held[7:8-FLAG_W], w_ram_rdata[ID_W-1:0]}
                               : {r_s1_held, r_s1_byte};

    always_comb begin
        w_push.num = w_s1_num;
        if (r_s1_hdr) begin
            w_push.e0 = '{out_byte: w_header[15:8], last: 1'b0};
            w_push.e1 = '{out_byte: w_header[7:0], last: 1'b1};
        end else begin
            w_push.e0 = '{out_byte: r_s1_byte, last: 1'b1};
            w_push.e1 = '{out_byte: r_s1_byte, last: 1'b1};
        end
    end

    tpr_out_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_out  (o_out),
        .o_count(w_q_count)
    );

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !i_in.ready)
        else $error("input accepted during table clearing");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.action) |=> !r_s1_valid)
        else $error("table write produced a result");

    a_pair_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_hdr) |-> (r_pos == POS_W'(3)))
        else $error("header pair out of step with byte position");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= (Q_CW + 1)'(Q_DEPTH))
        else $error("result queue overrun");
endmodule

// ----- hdl/tpr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module tpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/tpr_out_queue.sv -----
// Small result queue that takes one or two bytes a cycle and drives the output channel.
// Depends on tpr_pkg and tpr_out_if.
module tpr_out_queue
    import tpr_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_q_push         i_push,
    tpr_out_if.source       o_out,
    output logic [Q_CW-1:0] o_count
);
    t_q_entry        r_entries [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_count;
    logic [Q_AW-1:0] n_wr;
    logic [Q_AW-1:0] n_rd;
    logic [Q_CW-1:0] n_count;
    logic            w_pop;
    logic [Q_AW-1:0] w_wr1;

    assign w_pop = o_out.valid && o_out.ready;
    assign w_wr1 = r_wr + Q_AW'(1);

    always_comb begin
        n_wr    = r_wr + Q_AW'(i_push.num);
        n_rd    = w_pop ? r_rd + Q_AW'(1) : r_rd;
        n_count = r_count + Q_CW'(i_push.num) - Q_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_entries[r_wr] <= i_push.e0;
        end
        if (i_push.num == 2'd2) begin
            r_entries[w_wr1] <= i_push.e1;
        end
    end

    assign o_out.valid    = (r_count != '0);
    assign o_out.out_byte = r_entries[r_rd].out_byte;
    assign o_out.last     = r_entries[r_rd].last;
    assign o_count        = r_count;
endmodule

// ----- bench/tb_ts_packet_pid_remapper_core.sv -----
// Testbench for ts_packet_pid_remapper_core: stream bytes and remap table writes with
// random idling on both channels, checked against an in-bench identifier remap predictor.
// Depends on tpr_pkg, tpr_in_if, tpr_out_if and the core RTL.
module tb_ts_packet_pid_remapper_core;
    import tpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_STREAM    = 1'b0;
    localparam logic ACT_WRITE     = 1'b1;
    localparam int   LIMIT_CYCLES  = 1_000_000;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   REPORT_MAX    = 10;

    typedef struct {
        logic            action;
        logic [7:0]      data_byte;
        logic [ID_W-1:0] map_source;
        logic [ID_W-1:0] map_target;
        logic            map_enable;
    } ts_item_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
    } ts_byte_t;

    logic i_clk;
    logic i_rst_n;

    tpr_in_if  in_ch();
    tpr_out_if out_ch();

    ts_packet_pid_remapper_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [ID_W:0]      remap_tbl [ID_COUNT];
    logic [POS_W-1:0]   stream_pos;
    logic [7:0]         held_hdr;
    ts_byte_t           expected_bytes[$];

    logic [ID_W-1:0]    pid_pool [8];
    logic [ID_W-1:0]    hdr_pid;

    bit src_quiet;
    bit sink_quiet;
    int hold_req;
    int cycles;
    int mismatches;
    int items_sent;
    int bytes_checked;
    int table_writes;
    int headers_seen;
    int headers_remapped;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycles, expected_bytes.size());
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic predict_item(input ts_item_t it);
        logic [15:0]   hdr;
        logic [ID_W:0] entry;
        if (it.action == ACT_WRITE) begin
            table_writes++;
            if (int'(it.map_source) < ID_COUNT) begin
                remap_tbl[it.map_source] = {it.map_enable, it.map_target};
            end
        end else begin
            if (stream_pos == POS_HDR1) begin
                held_hdr = it.data_byte;
            end else if (stream_pos == POS_HDR2) begin
                hdr = {held_hdr, it.data_byte};
                headers_seen++;
                if (int'(hdr[ID_W-1:0]) < ID_COUNT) begin
                    entry = remap_tbl[hdr[ID_W-1:0]];
                    if (entry[ID_W]) begin
                        hdr = {hdr[15:ID_W], entry[ID_W-1:0]};
                        headers_remapped++;
                    end
                end
                expected_bytes.push_back('{hdr[15:8], 1'b0});
                expected_bytes.push_back('{hdr[7:0], 1'b1});
            end else begin
                expected_bytes.push_back('{it.data_byte, 1'b1});
            end
            stream_pos = (stream_pos == POS_LAST) ? '0 : stream_pos + POS_W'(1);
        end
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(30, 80);
        end
    endfunction

    task automatic send_item(input ts_item_t it);
        int gap;
        gap = (src_quiet || $urandom_range(0, 99) < 65) ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= it.action;
        in_ch.data_byte  <= it.data_byte;
        in_ch.map_source <= it.map_source;
        in_ch.map_target <= it.map_target;
        in_ch.map_enable <= it.map_enable;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        predict_item(it);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic ts_item_t mk_item(input logic act, input logic [7:0] data,
                                         input logic [ID_W-1:0] src,
                                         input logic [ID_W-1:0] tgt, input logic en);
        ts_item_t it;
        it = '{act, data, src, tgt, en};
        return it;
    endfunction

    function automatic ts_item_t next_random_item();
        ts_item_t it;
        int       wr_pct;
        it.action     = ACT_STREAM;
        it.data_byte  = 8'($urandom_range(0, 255));
        it.map_source = ID_W'($urandom_range(0, ID_COUNT - 1));
        it.map_target = ID_W'($urandom_range(0, ID_COUNT - 1));
        it.map_enable = 1'($urandom_range(0, 1));
        wr_pct = (stream_pos == POS_HDR2) ? 35 : 6;
        if ($urandom_range(0, 99) < wr_pct) begin
            it.action = ACT_WRITE;
            if ($urandom_range(0, 99) < 80) begin
                it.map_source = pid_pool[$urandom_range(0, 7)];
            end
            if (stream_pos == POS_HDR2 && $urandom_range(0, 1) == 1) begin
                it.map_source = hdr_pid;
            end
            it.map_enable = ($urandom_range(0, 99) < 75);
        end else if (stream_pos == POS_HDR1) begin
            hdr_pid = ($urandom_range(0, 99) < 85) ? pid_pool[$urandom_range(0, 7)]
                                                   : ID_W'($urandom_range(0, ID_COUNT - 1));
            it.data_byte = {3'($urandom_range(0, 7)), hdr_pid[ID_W-1:8]};
        end else if (stream_pos == POS_HDR2) begin
            it.data_byte = hdr_pid[7:0];
        end
        return it;
    endfunction

    initial begin
        ts_byte_t got;
        ts_byte_t want;
        int       stall_left;
        int       hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got = '{out_ch.out_byte, out_ch.last};
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Unexpected result byte %02h last %0b at cycle %0d.",
                                 got.out_byte, got.last, cycles);
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (got.out_byte !== want.out_byte || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $display("Mismatch at cycle %0d: byte %02h last %0b, expected %02h %0b.",
                                     cycles, got.out_byte, got.last,
                                     want.out_byte, want.last);
                        end
                    end
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!sink_quiet && $urandom_range(0, 99) < 15) begin
                stall_left = idle_len() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // One header whose identifier is mapped before byte 1, with a write to another
    // entry while byte 1 is held, followed by payload bytes at the value extremes.
    task automatic test_first_header();
        send_item(mk_item(ACT_STREAM, 8'h47, '0, '0, 1'b0));
        send_item(mk_item(ACT_WRITE, 8'hff, ID_W'(ID_COUNT - 1), '0, 1'b1));
        send_item(mk_item(ACT_WRITE, 8'h00, '0, ID_W'(ID_COUNT - 1), 1'b1));
        send_item(mk_item(ACT_STREAM, 8'hff, '1, '1, 1'b1));
        send_item(mk_item(ACT_WRITE, 8'h5a, ID_W'('h0aaa), ID_W'('h0aaa), 1'b0));
        send_item(mk_item(ACT_STREAM, 8'hff, '0, '0, 1'b0));
        send_item(mk_item(ACT_STREAM, 8'h00, '1, '0, 1'b1));
        send_item(mk_item(ACT_STREAM, 8'hff, '0, '1, 1'b0));
        send_item(mk_item(ACT_STREAM, 8'h80, '0, '0, 1'b0));
        send_item(mk_item(ACT_STREAM, 8'h01, '0, '0, 1'b0));
        send_item(mk_item(ACT_WRITE, 8'h00, ID_W'('h1555), ID_W'('h0aaa), 1'b1));
        wait_drained();
    endtask

    task automatic test_random_stream(input int n, input bit quiet);
        src_quiet  = quiet;
        sink_quiet = quiet;
        for (int k = 3; k < 8; k++) begin
            pid_pool[k] = ID_W'($urandom_range(0, ID_COUNT - 1));
        end
        repeat (n) send_item(next_random_item());
        wait_drained();
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    // The receiver holds off while the sender keeps offering, so the result queue fills
    // and the core has to stall its input without losing a transaction.
    task automatic test_receiver_hold(input int n);
        src_quiet  = 1'b1;
        sink_quiet = 1'b1;
        hold_req   = HOLD_CYCLES;
        repeat (n) send_item(next_random_item());
        src_quiet = 1'b0;
        wait_drained();
        sink_quiet = 1'b0;
    endtask

    initial begin
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACT_STREAM;
        in_ch.data_byte  <= '0;
        in_ch.map_source <= '0;
        in_ch.map_target <= '0;
        in_ch.map_enable <= 1'b0;
        i_rst_n          <= 1'b0;
        src_quiet        = 1'b0;
        sink_quiet       = 1'b0;
        hold_req         = 0;
        mismatches       = 0;
        items_sent       = 0;
        bytes_checked    = 0;
        table_writes     = 0;
        headers_seen     = 0;
        headers_remapped = 0;
        for (int k = 0; k < ID_COUNT; k++) begin
            remap_tbl[k] = '0;
        end
        stream_pos  = '0;
        held_hdr    = '0;
        hdr_pid     = '0;
        pid_pool[0] = '0;
        pid_pool[1] = ID_W'(ID_COUNT - 1);
        pid_pool[2] = ID_W'('h0100);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_header();
        test_random_stream(600, 1'b0);
        test_random_stream(300, 1'b1);
        test_receiver_hold(120);
        test_random_stream(800, 1'b0);

        $display("Sent %0d transactions (%0d table writes), checked %0d result bytes.",
                 items_sent, table_writes, bytes_checked);
        $display("Headers: %0d seen, %0d remapped; one %0d-cycle receiver hold-off.",
                 headers_seen, headers_remapped, HOLD_CYCLES);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tpr_pkg.sv
hdl/tpr_if.sv
hdl/tpr_ram.sv
hdl/tpr_out_queue.sv
hdl/ts_packet_pid_remapper_core.sv
bench/tb_ts_packet_pid_remapper_core.sv
